>>> sv/nlbs_pkg.sv
// ----------------------------------------------------------------------------
// nlbs_pkg
// Shared constants and the command word passed from the classifier front end
// to the result sequencer of the newline normaliser.
// ----------------------------------------------------------------------------
package nlbs_pkg;

    // UTF-8 byte-order mark and line-end characters
    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Number of held BOM prefix bytes to release ahead of the body byte
    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_EF   = 2'd1;
    localparam logic [1:0] PRE_EFBB = 2'd2;

    // One classified input word: prefix release, optional body byte, end flag.
    // A command with no prefix and no body byte is only queued on the final
    // word and then stands for a bare end marker.
    typedef struct packed {
        logic [1:0] pre_cnt;
        logic       body_vld;
        logic [7:0] body_byte;
        logic       last;
    } nlbs_cmd_t;

endpackage

>>> sv/newline_normaliser_bom_strip_top.sv
// ----------------------------------------------------------------------------
// newline_normaliser_bom_strip_top
// CR/LF to LF normaliser with removal of a leading UTF-8 byte-order mark.
//
//   channel | handshake         | words
//   --------+-------------------+---------------------------------
//   input   | push / full       | in_byte, in_last
//   output  | pop / empty       | out_byte, has_byte, out_last
//
// One input word is accepted per cycle while the command queue has room.
// Each input word yields zero to three output words; the sequencer sends one
// per cycle while pop is high, so a released BOM prefix holds the queue head
// until all its words are popped. Each command is registered in the queue first.
// rst_n clears the BOM/CR tracking, the queue and the sequencer at once.
// ----------------------------------------------------------------------------
module newline_normaliser_bom_strip_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);
    import nlbs_pkg::*;

    logic      in_vld;
    logic      cmd_push;
    nlbs_cmd_t cmd;
    nlbs_cmd_t head_cmd;
    logic      head_empty;
    logic      head_pop;

    assign in_vld = push && !full;

    // Classifier
    nlbs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    // Command queue
    nlbs_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .wr_cmd (cmd),
        .full   (full),
        .pop    (head_pop),
        .rd_cmd (head_cmd),
        .empty  (head_empty)
    );

    // Result sequencer
    nlbs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .out_last   (out_last)
    );

endmodule

>>> sv/nlbs_front.sv
// ----------------------------------------------------------------------------
// nlbs_front
// Classifier: tracks the BOM match at text start and the CR/LF pairing, and
// turns each accepted input word with something to emit into one command for the sequencer.
// ----------------------------------------------------------------------------
module nlbs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              cmd_push,
    output nlbs_pkg::nlbs_cmd_t cmd
);
    import nlbs_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_ONE,
        PH_TWO,
        PH_BODY
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       skip_reg;
    logic       skip_next;
    logic       taken;
    logic [1:0] pre_cnt;
    logic       body_vld;
    logic [7:0] body_byte;

    // BOM matcher, CR/LF rewrite and end-of-text release
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        taken      = 1'b0;
        pre_cnt    = PRE_NONE;
        body_vld   = 1'b0;
        body_byte  = in_byte;

        case (phase_reg)
            PH_START:
            begin
                if (in_byte == BOM_B0)
                begin
                    phase_next = PH_ONE;
                    taken      = 1'b1;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_ONE:
            begin
                if (in_byte == BOM_B1)
                begin
                    phase_next = PH_TWO;
                    taken      = 1'b1;
                end
                else
                begin
                    pre_cnt    = PRE_EF;
                    phase_next = PH_BODY;
                end
            end
            PH_TWO:
            begin
                if (in_byte == BOM_B2)
                begin
                    taken = 1'b1;
                end
                else
                begin
                    pre_cnt = PRE_EFBB;
                end
                phase_next = PH_BODY;
            end
            default:
            begin
                phase_next = PH_BODY;
            end
        endcase

        // body byte: CR becomes LF, LF right after CR is dropped
        if (!taken)
        begin
            if (in_byte == CH_CR)
            begin
                body_vld  = 1'b1;
                body_byte = CH_LF;
                skip_next = 1'b1;
            end
            else if (in_byte == CH_LF && skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                body_vld  = 1'b1;
                skip_next = 1'b0;
            end
        end

        // text ends inside a partial BOM: release what is held
        if (in_last)
        begin
            if (phase_next == PH_ONE)
            begin
                pre_cnt = PRE_EF;
            end
            else if (phase_next == PH_TWO)
            begin
                pre_cnt = PRE_EFBB;
            end
            phase_next = PH_START;
            skip_next  = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            skip_reg  <= 1'b0;
        end
        else if (in_vld)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
        end
    end

    // Queue a command only when the word yields something to emit
    assign cmd_push       = in_vld && (pre_cnt != PRE_NONE || body_vld || in_last);
    assign cmd.pre_cnt    = pre_cnt;
    assign cmd.body_vld   = body_vld;
    assign cmd.body_byte  = body_byte;
    assign cmd.last       = in_last;

endmodule

>>> sv/nlbs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// nlbs_cmd_fifo
// Small command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module nlbs_cmd_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nlbs_pkg::nlbs_cmd_t wr_cmd,
    output logic                full,
    input  logic                pop,
    output nlbs_pkg::nlbs_cmd_t rd_cmd,
    output logic                empty
);
    import nlbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nlbs_cmd_t          cmd_mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = cmd_mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/nlbs_back.sv
// ----------------------------------------------------------------------------
// nlbs_back
// Result sequencer: expands the command at the queue head into one to three
// output words, one per pop.
// ----------------------------------------------------------------------------
module nlbs_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  nlbs_pkg::nlbs_cmd_t head_cmd,
    input  logic                head_empty,
    output logic                head_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output logic                out_last
);
    import nlbs_pkg::*;

    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic [1:0] total;
    logic [1:0] final_step;
    logic       at_final;
    logic       take;

    // Results in this command: held prefix bytes plus the body byte
    assign total      = head_cmd.pre_cnt + {1'b0, head_cmd.body_vld};
    assign final_step = (total == 2'd0) ? 2'd0 : total - 2'd1;
    assign at_final   = (step_reg == final_step);

    // Current output word
    always_comb
    begin
        out_byte = 8'h00;
        has_byte = 1'b0;
        if (step_reg < head_cmd.pre_cnt)
        begin
            out_byte = (step_reg == 2'd0) ? BOM_B0 : BOM_B1;
            has_byte = 1'b1;
        end
        else if (head_cmd.body_vld)
        begin
            out_byte = head_cmd.body_byte;
            has_byte = 1'b1;
        end
    end

    assign empty    = head_empty;
    assign out_last = head_cmd.last && at_final;
    assign take     = pop && !head_empty;
    assign head_pop = take && at_final;
    assign step_next = at_final ? 2'd0 : step_reg + 2'd1;

    // Word index within the current command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
        end
        else if (take)
        begin
            step_reg <= step_next;
        end
    end

endmodule
